/* hw/rtl/cscr_pkg.sv */
`timescale 1ns / 1ps

package cscr_pkg;

  localparam int CSCR_MAX_SEGMENTS = 1024;

  localparam logic [30:0] RADIUS_RESET      = 31'd65536;
  localparam logic [20:0] FRICTION_RESET    = 21'd32768;
  localparam logic [20:0] RESTITUTION_RESET = 21'd32768;
  localparam logic [30:0] MASS_RESET        = 31'd65536;
  localparam logic [30:0] TIME_STEP_RESET   = 31'd1092;

  localparam logic [2:0] REG_RADIUS      = 3'd0;
  localparam logic [2:0] REG_FRICTION    = 3'd1;
  localparam logic [2:0] REG_RESTITUTION = 3'd2;
  localparam logic [2:0] REG_MASS        = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;

  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  typedef enum logic [6:0] {
    OP_BBOX, OP_L2A, OP_L2B, OP_L2C, OP_ZCHK,
    OP_DOTA, OP_DOTB, OP_DOTC, OP_PCHK, OP_PSET,
    OP_CPA, OP_CPB, OP_CPC, OP_EY,
    OP_E2A, OP_E2B, OP_E2C, OP_E2D,
    OP_VA, OP_VB, OP_VC, OP_VD, OP_VE,
    OP_RATIO, OP_RSET, OP_IA, OP_IB, OP_IC,
    OP_SLEN, OP_SLSET, OP_UXD, OP_UXSET, OP_UYD, OP_UYSET,
    OP_SPA, OP_SPB, OP_SPC,
    OP_PARA, OP_PARB, OP_PARC, OP_PERY,
    OP_LPA, OP_LPB, OP_LPC, OP_LPSET,
    OP_LQA, OP_LQB, OP_LQC, OP_LQSET,
    OP_FRA, OP_FRB, OP_FCHK,
    OP_FXA, OP_FXB, OP_FXSET, OP_FYSET,
    OP_RA, OP_RB, OP_RC, OP_RD,
    OP_ELA, OP_ELB, OP_ELC, OP_ELSET, OP_ECHK,
    OP_PXA, OP_PXB, OP_PXSET, OP_PYA, OP_PYB, OP_PYSET,
    OP_END
  } op_t;

  typedef enum logic [1:0] {
    IT_DIV  = 2'd0,
    IT_FRAC = 2'd1,
    IT_SQRT = 2'd2
  } iter_mode_t;

  typedef struct packed {
    op_t  op;
    logic run;
    logic load_body;
    logic load_seg;
  } cmd_t;

  typedef struct packed {
    logic cond;
    logic started;
    logic done;
    logic last;
    logic out_full;
  } status_t;

  typedef struct packed {
    logic        start;
    iter_mode_t  mode;
    logic [63:0] num;
    logic [63:0] den;
  } iter_req_t;

endpackage

/* hw/rtl/cscr_iter.sv */
`timescale 1ns / 1ps

module cscr_iter
  import cscr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  iter_req_t          req,
  output logic signed [63:0] res,
  output logic               done
);

  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] FRAC_STEPS = 7'd16;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  logic        busy;
  logic [6:0]  cnt;
  iter_mode_t  mode;
  logic        neg;
  logic [64:0] rem;
  logic [63:0] q;
  logic [63:0] den;

  logic        shin;
  logic [64:0] r2;
  logic        ge_d;
  logic [34:0] t;
  logic [34:0] trial;
  logic        ge_s;

  always_comb begin
    shin  = (mode == IT_DIV) ? q[63] : 1'b0;
    r2    = {rem[63:0], shin};
    ge_d  = r2 >= {1'b0, den};
    t     = {rem[32:0], q[63:62]};
    trial = {1'b0, den[31:0], 2'b01};
    ge_s  = t >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        unique case (req.mode)
          IT_DIV:  cnt <= DIV_STEPS;
          IT_FRAC: cnt <= FRAC_STEPS;
          default: cnt <= SQRT_STEPS;
        endcase
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      neg  <= req.num[63];
      unique case (req.mode)
        IT_DIV: begin
          q   <= req.num[63] ? (~req.num + 64'd1) : req.num;
          rem <= '0;
          den <= req.den;
        end
        IT_FRAC: begin
          q   <= '0;
          rem <= {1'b0, req.num};
          den <= req.den;
        end
        default: begin
          q   <= req.num;
          rem <= '0;
          den <= '0;
        end
      endcase
    end else if (busy) begin
      if (mode == IT_SQRT) begin
        rem <= ge_s ? {30'b0, t - trial} : {30'b0, t};
        den <= {32'b0, den[30:0], ge_s};
        q   <= {q[61:0], 2'b00};
      end else begin
        rem <= ge_d ? (r2 - {1'b0, den}) : r2;
        q   <= {q[62:0], ge_d};
      end
    end
  end

  always_comb begin
    unique case (mode)
      IT_DIV:  res = neg ? signed'(~q + 64'd1) : signed'(q);
      IT_FRAC: res = signed'({48'b0, q[15:0]});
      default: res = signed'({32'b0, den[31:0]});
    endcase
  end

endmodule

/* hw/rtl/cscr_datapath.sv */
`timescale 1ns / 1ps

module cscr_datapath
  import cscr_pkg::*;
#(
  parameter int MAX_SEGMENTS = CSCR_MAX_SEGMENTS
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output status_t      st,
  input  logic [319:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,
  input  logic         wr_en,
  input  logic [2:0]   wr_index,
  input  logic [30:0]  wr_data
);

  localparam int CW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CW-1:0] COUNT_TOP = CW'(MAX_SEGMENTS - 1);

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    else if (v < -67'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] qm(input logic signed [65:0] p);
    logic signed [66:0] e;
    e = p;
    return sat32(e >>> 16);
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [66:0] ea;
    logic signed [66:0] eb;
    ea = a;
    eb = b;
    return sat32(ea + eb);
  endfunction

  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [66:0] ea;
    logic signed [66:0] eb;
    ea = a;
    eb = b;
    return sat32(ea - eb);
  endfunction

  logic [30:0] radius;
  logic [20:0] friction;
  logic [20:0] restitution;
  logic [30:0] mass;
  logic [30:0] time_step;

  logic signed [31:0] px, py, vx, vy, fbx, fby;
  logic [CW-1:0]      count;
  logic               touch_seen;
  logic [CW-1:0]      touch_idx;

  logic signed [31:0] ax, ay, bx, by;
  logic               last;
  logic signed [31:0] sx, sy, dx, dy;
  logic [63:0]        slen2;
  logic signed [64:0] acc;
  logic [16:0]        part;
  logic signed [31:0] cx, cy, ex, ey;
  logic               ok;
  logic signed [31:0] ratio, ix, iy, ux, uy, spar;
  logic signed [31:0] parx, pary, perx, pery;
  logic [31:0]        slen, lpar, lper, elen;
  logic signed [31:0] fr, frx, fry, rx, ry;

  logic signed [31:0] opx, opy, ofx, ofy;
  logic               otouch;
  logic [CW-1:0]      oidx;

  logic signed [32:0] ma, mb;
  logic               mul_en;
  logic signed [65:0] p;
  logic signed [65:0] accp;

  iter_req_t          req;
  logic signed [63:0] ires;
  logic signed [66:0] ires_e;
  logic               idone;
  logic               cond;
  logic               out_full;

  logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [33:0] r_e, px_hi, px_lo, py_hi, py_lo;
  logic               miss;
  logic [32:0]        fdiff;
  logic [30:0]        dt_eff;

  cscr_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .res  (ires),
    .done (idone)
  );

  always_comb begin
    lo_x   = (ax <= bx) ? ax : bx;
    hi_x   = (ax > bx) ? ax : bx;
    lo_y   = (ay <= by) ? ay : by;
    hi_y   = (ay > by) ? ay : by;
    r_e    = signed'({3'b0, radius});
    px_hi  = 34'(px) + r_e;
    px_lo  = 34'(px) - r_e;
    py_hi  = 34'(py) + r_e;
    py_lo  = 34'(py) - r_e;
    miss   = (34'(lo_x) > px_hi) || (34'(hi_x) < px_lo) ||
             (34'(lo_y) > py_hi) || (34'(hi_y) < py_lo);
    accp   = acc + p;
    ires_e = ires;
    fdiff  = {1'b0, lpar} - {1'b0, fr};
    dt_eff = (time_step == 31'd0) ? 31'd1 : time_step;
    out_full = m_tvalid && !m_tready;
  end

  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b0;
    if (cmd.run) begin
      mul_en = 1'b1;
      unique case (cmd.op)
        OP_L2A:  begin ma = sx; mb = sx; end
        OP_L2B:  begin ma = sy; mb = sy; end
        OP_DOTA: begin ma = dx; mb = sx; end
        OP_DOTB: begin ma = dy; mb = sy; end
        OP_CPA:  begin ma = sx; mb = signed'({16'b0, part}); end
        OP_CPB:  begin ma = sy; mb = signed'({16'b0, part}); end
        OP_E2A, OP_ELA: begin ma = ex; mb = ex; end
        OP_E2B, OP_ELB: begin ma = ey; mb = ey; end
        OP_E2C:  begin ma = r_e[32:0]; mb = r_e[32:0]; end
        OP_VA:   begin ma = ex; mb = vx; end
        OP_VB:   begin ma = ey; mb = vy; end
        OP_VC:   begin ma = sy; mb = vx; end
        OP_VD:   begin ma = sx; mb = vy; end
        OP_IA:   begin ma = vx; mb = ratio; end
        OP_IB:   begin ma = vy; mb = ratio; end
        OP_SPA:  begin ma = ix; mb = ux; end
        OP_SPB:  begin ma = iy; mb = uy; end
        OP_PARA: begin ma = ux; mb = spar; end
        OP_PARB: begin ma = uy; mb = spar; end
        OP_LPA:  begin ma = parx; mb = parx; end
        OP_LPB:  begin ma = pary; mb = pary; end
        OP_LQA:  begin ma = perx; mb = perx; end
        OP_LQB:  begin ma = pery; mb = pery; end
        OP_FRA:  begin ma = signed'({1'b0, lper}); mb = signed'({12'b0, friction}); end
        OP_FXA:  begin ma = parx; mb = signed'(fdiff); end
        OP_FXB:  begin ma = pary; mb = signed'(fdiff); end
        OP_RA:   begin ma = ssub(32'sd0, perx); mb = signed'({12'b0, restitution}); end
        OP_RB:   begin ma = ssub(32'sd0, pery); mb = signed'({12'b0, restitution}); end
        OP_PXA:  begin ma = ex; mb = r_e[32:0]; end
        OP_PYA:  begin ma = ey; mb = r_e[32:0]; end
        default: mul_en = 1'b0;
      endcase
    end
  end

  always_comb begin
    cond = 1'b0;
    req  = '0;
    if (cmd.run) begin
      unique case (cmd.op)
        OP_BBOX: cond = miss;
        OP_ZCHK: cond = (slen2 == 64'd0);
        OP_PCHK: begin
          cond = (acc <= 65'sd0) || (acc[63:0] >= slen2);
          if (!cond) begin
            req.start = 1'b1;
            req.mode  = IT_FRAC;
            req.num   = acc[63:0];
            req.den   = slen2;
          end
        end
        OP_E2D:  cond = acc > p;
        OP_VE:   cond = !(ok && (acc < p));
        OP_FCHK: cond = (lpar == 32'd0) || (lpar < unsigned'(fr));
        OP_ECHK: cond = (elen == 32'd0);
        OP_RATIO: begin
          req.start = 1'b1;
          req.mode  = IT_DIV;
          req.num   = {17'b0, mass, 16'b0};
          req.den   = {33'b0, dt_eff};
        end
        OP_SLEN: begin
          req.start = 1'b1;
          req.mode  = IT_SQRT;
          req.num   = slen2;
        end
        OP_UXD: begin
          req.start = 1'b1;
          req.mode  = IT_DIV;
          req.num   = {{16{sx[31]}}, sx, 16'b0};
          req.den   = {32'b0, slen};
        end
        OP_UYD: begin
          req.start = 1'b1;
          req.mode  = IT_DIV;
          req.num   = {{16{sy[31]}}, sy, 16'b0};
          req.den   = {32'b0, slen};
        end
        OP_LPC, OP_LQC, OP_ELC: begin
          req.start = 1'b1;
          req.mode  = IT_SQRT;
          req.num   = accp[63:0];
        end
        OP_FXB, OP_FXSET: begin
          req.start = 1'b1;
          req.mode  = IT_DIV;
          req.num   = p[63:0];
          req.den   = {32'b0, lpar};
        end
        OP_PXB, OP_PYB: begin
          req.start = 1'b1;
          req.mode  = IT_DIV;
          req.num   = p[63:0];
          req.den   = {32'b0, elen};
        end
        default: cond = 1'b0;
      endcase
    end
  end

  always_comb begin
    st.cond     = cond;
    st.started  = req.start;
    st.done     = idone;
    st.last     = last;
    st.out_full = out_full;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p <= ma * mb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seg) begin
      ax   <= s_tdata[223:192];
      ay   <= s_tdata[255:224];
      bx   <= s_tdata[287:256];
      by   <= s_tdata[319:288];
      last <= s_tlast;
    end
    if (cmd.run) begin
      unique case (cmd.op)
        OP_BBOX: begin
          sx <= ssub(bx, ax);
          sy <= ssub(by, ay);
          dx <= ssub(px, ax);
          dy <= ssub(py, ay);
        end
        OP_L2B, OP_DOTB, OP_E2B, OP_VB, OP_SPB, OP_LPB, OP_LQB, OP_ELB, OP_VD: begin
          acc <= p[64:0];
        end
        OP_L2C:  slen2 <= accp[63:0];
        OP_DOTC, OP_E2C: acc <= accp[64:0];
        OP_PCHK: begin
          if (acc <= 65'sd0) part <= '0;
          else if (acc[63:0] >= slen2) part <= 17'h10000;
        end
        OP_PSET:  part <= {1'b0, ires[15:0]};
        OP_CPB:   cx <= sadd(ax, qm(p));
        OP_CPC: begin
          cy <= sadd(ay, qm(p));
          ex <= ssub(px, cx);
        end
        OP_EY:    ey <= ssub(py, cy);
        OP_VC:    ok <= accp < 66'sd0;
        OP_RSET:  ratio <= (ires > 64'sd2147483647) ? 32'sh7fffffff : ires[31:0];
        OP_IB:    ix <= sadd(fbx, qm(p));
        OP_IC:    iy <= sadd(fby, qm(p));
        OP_SLSET: slen <= ires[31:0];
        OP_UXSET: ux <= ires[31:0];
        OP_UYSET: uy <= ires[31:0];
        OP_SPC:   spar <= sat32(67'(accp >>> 16));
        OP_PARB:  parx <= qm(p);
        OP_PARC: begin
          pary <= qm(p);
          perx <= ssub(ix, parx);
        end
        OP_PERY:  pery <= ssub(iy, pary);
        OP_LPSET: lpar <= ires[31:0];
        OP_LQSET: lper <= ires[31:0];
        OP_FRB:   fr <= qm(p);
        OP_FCHK: begin
          if (lpar == 32'd0) begin
            frx <= parx;
            fry <= pary;
          end else if (lpar < unsigned'(fr)) begin
            frx <= '0;
            fry <= '0;
          end
        end
        OP_FXSET: frx <= ires[31:0];
        OP_FYSET: fry <= ires[31:0];
        OP_RB:    rx <= qm(p);
        OP_RC:    ry <= qm(p);
        OP_ELSET: elen <= ires[31:0];
        OP_END: begin
          if (last && !out_full) begin
            opx    <= px;
            opy    <= py;
            ofx    <= fbx;
            ofy    <= fby;
            otouch <= touch_seen;
            oidx   <= touch_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RESET;
      friction    <= FRICTION_RESET;
      restitution <= RESTITUTION_RESET;
      mass        <= MASS_RESET;
      time_step   <= TIME_STEP_RESET;
      px          <= '0;
      py          <= '0;
      vx          <= '0;
      vy          <= '0;
      fbx         <= '0;
      fby         <= '0;
      count       <= '0;
      touch_seen  <= 1'b0;
      touch_idx   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_RADIUS:      radius      <= wr_data;
          REG_FRICTION:    friction    <= wr_data[20:0];
          REG_RESTITUTION: restitution <= wr_data[20:0];
          REG_MASS:        mass        <= wr_data;
          REG_TIME_STEP:   time_step   <= wr_data;
          default: begin
          end
        endcase
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load_body) begin
        px         <= s_tdata[31:0];
        py         <= s_tdata[63:32];
        vx         <= s_tdata[95:64];
        vy         <= s_tdata[127:96];
        fbx        <= s_tdata[159:128];
        fby        <= s_tdata[191:160];
        count      <= '0;
        touch_seen <= 1'b0;
        touch_idx  <= '0;
      end
      if (cmd.run) begin
        unique case (cmd.op)
          OP_E2D: begin
            if (!cond && !touch_seen) begin
              touch_seen <= 1'b1;
              touch_idx  <= count;
            end
          end
          OP_RC:    fbx <= sadd(fbx, ssub(sadd(frx, rx), ix));
          OP_RD:    fby <= sadd(fby, ssub(sadd(fry, ry), iy));
          OP_ECHK: begin
            if (elen == 32'd0) begin
              px <= cx;
              py <= cy;
            end
          end
          OP_PXSET: px <= sadd(cx, sat32(ires_e));
          OP_PYSET: py <= sadd(cy, sat32(ires_e));
          OP_END: begin
            if (last) begin
              if (!out_full) begin
                m_tvalid   <= 1'b1;
                count      <= '0;
                touch_seen <= 1'b0;
                touch_idx  <= '0;
              end
            end else if (count < COUNT_TOP) begin
              count <= count + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign m_tdata = {5'b0, 10'(oidx), otouch, ofy, ofx, opy, opx};

endmodule

/* hw/rtl/cscr_ctrl.sv */
`timescale 1ns / 1ps

module cscr_ctrl
  import cscr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    s_tuser,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;
  logic   accept;

  always_comb begin
    s_tready      = (state == S_IDLE);
    accept        = s_tready && s_tvalid;
    cmd.op        = op;
    cmd.run       = (state == S_RUN);
    cmd.load_body = accept && (s_tuser == KIND_BODY);
    cmd.load_seg  = accept && (s_tuser == KIND_SEGMENT);
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      S_IDLE: begin
        if (cmd.load_seg) begin
          state_next = S_RUN;
          op_next    = OP_BBOX;
        end
      end
      S_RUN: begin
        if (st.started) begin
          state_next = S_WAIT;
        end else begin
          unique case (op)
            OP_BBOX, OP_ZCHK, OP_E2D, OP_VE, OP_ECHK:
              op_next = st.cond ? OP_END : op_t'(op + 1'b1);
            OP_PCHK: op_next = OP_CPA;
            OP_FCHK: op_next = st.cond ? OP_RA : op_t'(op + 1'b1);
            OP_END: begin
              if (!(st.last && st.out_full)) state_next = S_IDLE;
            end
            default: op_next = op_t'(op + 1'b1);
          endcase
        end
      end
      S_WAIT: begin
        if (st.done) begin
          state_next = S_RUN;
          op_next    = op_t'(op + 1'b1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_BBOX;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule

/* hw/rtl/circle_segment_collision_response.sv */
`timescale 1ns / 1ps

// Resolves a round body against a ground polyline, one segment word at a time.
// Input words: tuser low selects the kind. A body word (tuser 0) loads position,
// velocity and force. A segment word (tuser 1) is one ground segment; tlast
// marks the final segment of the polyline.
// A segment whose box misses the body skips to the end step. A full contact
// runs a sequence of about 70 micro steps on one shared 33x33 multiplier plus
// one iterative divide and square root unit: a 16-step fraction, seven
// 64-step divisions and four 32-step roots. The next word is taken once the
// previous one is finished. The result word comes from the last segment and
// sits in an output register; a stalled receiver does not block new words
// until the next last segment, which then waits for the register to drain.
// Configuration is written through wr_en, wr_index and wr_data while idle;
// the user must keep to that, as the block itself does not enforce it.
// Reset restores the register defaults and clears the body state, the segment
// count and the touch record; no clearing pass is needed.
module circle_segment_collision_response
  import cscr_pkg::*;
#(
  parameter int MAX_SEGMENTS = CSCR_MAX_SEGMENTS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, vel_x, vel_y, force_x, force_y,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y
  input  logic [319:0] s_tdata,
  // kind
  input  logic         s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_pos_x, new_pos_y, new_force_x, new_force_y, touched, first_touch_index
  output logic [143:0] m_tdata,
  input  logic         wr_en,
  input  logic [2:0]   wr_index,
  input  logic [30:0]  wr_data
);

  cmd_t    cmd;
  status_t st;

  cscr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .st       (st),
    .cmd      (cmd)
  );

  cscr_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  a_no_accept_while_running: assert property (@(posedge clk) disable iff (rst)
    cmd.run |-> !s_tready)
    else $error("input accepted while a segment is being resolved");

  a_start_only_when_running: assert property (@(posedge clk) disable iff (rst)
    st.started |-> cmd.run)
    else $error("iterative unit started outside a micro step");

  a_result_from_end_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.run && cmd.op == OP_END))
    else $error("result word raised without an end step");

endmodule
